/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed: property violated");
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/core/zsvf_pkg.sv */
// ----------------------------------------------------------------------------
// zsvf_pkg
// Widths, formats, codes and helpers of the zero-delay-feedback SVF.
// ----------------------------------------------------------------------------
package zsvf_pkg;

    // Sample and integrator state widths
    localparam int SAMPLE_W = 24;
    localparam int STATE_W  = 32;

    // Coefficient register widths and fixed-point alignment
    localparam int MODE_W   = 2;
    localparam int G_W      = 24;
    localparam int R_W      = 17;
    localparam int INV_W    = 25;
    localparam int G_FRAC   = 20;
    localparam int INV_FRAC = 24;
    localparam int R_SHIFT  = 5;

    // Multiplier operand and accumulator widths
    localparam int DAMP_W  = (((R_W + R_SHIFT) > G_W) ? (R_W + R_SHIFT) : G_W) + 1;
    localparam int COEF_W  = (DAMP_W > INV_W) ? DAMP_W : INV_W;
    localparam int NUM_W   = STATE_W + (COEF_W - G_FRAC) + 1;
    localparam int LO_W    = (NUM_W + 1) / 2;
    localparam int HI_W    = NUM_W - LO_W;
    localparam int MUL_A_W = LO_W + 1;
    localparam int MUL_B_W = COEF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = NUM_W + COEF_W + 1;
    localparam int RND_W   = ACC_W - G_FRAC;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = (INV_W > G_W) ? INV_W : G_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE = 2'd0,
        REG_GAIN_G      = 2'd1,
        REG_DAMPING_R   = 2'd2,
        REG_INV_DENOM   = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [MODE_W-1:0] MODE_RESET = '0;
    localparam logic [G_W-1:0]    G_RESET    = 24'd34333;
    localparam logic [R_W-1:0]    R_RESET    = 17'd328;
    localparam logic [INV_W-1:0]  INV_RESET  = 25'd16753747;

    // Output select codes; any code with the highpass bit picks highpass
    localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd2;

    // Rounding offsets (half an output LSB) for both product scales
    localparam logic signed [ACC_W-1:0] HALF_G   = ACC_W'(1) << (G_FRAC - 1);
    localparam logic signed [ACC_W-1:0] HALF_INV = ACC_W'(1) << (INV_FRAC - 1);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_CONSUME,
        ST_FINISH
    } state_t;

    // Multiply phases of the shared multiplier
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI,
        MUL_ACC
    } phase_t;

    // The four products of one sample, in order
    typedef enum logic [1:0] {
        STEP_DAMP,
        STEP_INV,
        STEP_GH,
        STEP_GB
    } step_t;

    // Controller to datapath commands
    typedef struct packed {
        logic   capture;
        phase_t phase;
        step_t  step;
        logic   consume;
        logic   finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } sts_t;

    // Saturate a rounded value to the state width
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [RND_W-1:0] v
    );
        logic signed [STATE_W-1:0] r;
        if (v[RND_W-1:STATE_W-1] == {(RND_W - STATE_W + 1){v[RND_W-1]}}) begin
            r = v[STATE_W-1:0];
        end else if (v[RND_W-1]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Saturate a state-width value to the sample width
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [STATE_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v[STATE_W-1:SAMPLE_W-1] == {(STATE_W - SAMPLE_W + 1){v[STATE_W-1]}}) begin
            r = v[SAMPLE_W-1:0];
        end else if (v[STATE_W-1]) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

/* rtl/core/zdf_state_variable_filter.sv */
// ----------------------------------------------------------------------------
// zdf_state_variable_filter
// Two-pole zero-delay-feedback state variable filter: lowpass, bandpass or
// highpass of each input sample, fixed point, saturating.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Direction
//  input     s_valid s_ready s_sample_in              in
//  output    m_valid m_ready m_sample_out             out
//  config    cfg_valid cfg_ready cfg_index cfg_data   in, always ready
//
//  Each sample is taken in the idle state and then runs four products
//  on one shared multiplier, each split into two halves (low, high,
//  accumulate, use), before a finish step loads the output register.
//  The next sample is accepted only after the finish step.
//  A stalled output holds only the finish step; the next sample is taken
//  while the previous result still waits. Reset is synchronous, no sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zdf_state_variable_filter (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [zsvf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [zsvf_pkg::CFG_W-1:0]               cfg_data,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [zsvf_pkg::SAMPLE_W-1:0]     s_sample_in,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [zsvf_pkg::SAMPLE_W-1:0]     m_sample_out
);

    zsvf_pkg::cmd_t cmd;
    zsvf_pkg::sts_t sts;

    // Configuration writes are always accepted
    assign cfg_ready = 1'b1;

    zsvf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    zsvf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_sample_in  (s_sample_in),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    // An accepted sample makes the block busy on the next cycle
    `ASSERT_PROP(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    // A new output beat only comes from a finish command
    `ASSERT_PROP(a_out_from_finish, aclk, aresetn, $rose(m_valid) |-> $past(cmd.finish))
    // Never overwrite a pending output beat
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, cmd.finish && !sts.out_free)
    // Capture only on an input beat
    `ASSERT_NEVER(a_capture_on_beat, aclk, aresetn, cmd.capture && !(s_valid && s_ready))

endmodule

/* rtl/core/zsvf_ctrl.sv */
// ----------------------------------------------------------------------------
// zsvf_ctrl
// Sequencer: walks one sample through four split products on the shared
// multiplier and hands the result to the output register.
// ----------------------------------------------------------------------------
module zsvf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  zsvf_pkg::sts_t   sts,
    output zsvf_pkg::cmd_t   cmd
);

    zsvf_pkg::state_t state_reg, state_next;
    zsvf_pkg::step_t  step_reg, step_next;

    // Hold state and product step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zsvf_pkg::ST_IDLE;
            step_reg  <= zsvf_pkg::STEP_DAMP;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Advance through the product phases and drive commands
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.phase   = zsvf_pkg::MUL_NONE;
        cmd.step    = step_reg;
        cmd.consume = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            zsvf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    step_next   = zsvf_pkg::STEP_DAMP;
                    state_next  = zsvf_pkg::ST_MUL_LO;
                end
            end
            zsvf_pkg::ST_MUL_LO: begin
                cmd.phase  = zsvf_pkg::MUL_LO;
                state_next = zsvf_pkg::ST_MUL_HI;
            end
            zsvf_pkg::ST_MUL_HI: begin
                cmd.phase  = zsvf_pkg::MUL_HI;
                state_next = zsvf_pkg::ST_MUL_ACC;
            end
            zsvf_pkg::ST_MUL_ACC: begin
                cmd.phase  = zsvf_pkg::MUL_ACC;
                state_next = zsvf_pkg::ST_CONSUME;
            end
            zsvf_pkg::ST_CONSUME: begin
                cmd.consume = 1'b1;
                case (step_reg)
                    zsvf_pkg::STEP_DAMP: begin
                        step_next  = zsvf_pkg::STEP_INV;
                        state_next = zsvf_pkg::ST_MUL_LO;
                    end
                    zsvf_pkg::STEP_INV: begin
                        step_next  = zsvf_pkg::STEP_GH;
                        state_next = zsvf_pkg::ST_MUL_LO;
                    end
                    zsvf_pkg::STEP_GH: begin
                        step_next  = zsvf_pkg::STEP_GB;
                        state_next = zsvf_pkg::ST_MUL_LO;
                    end
                    default: begin
                        state_next = zsvf_pkg::ST_FINISH;
                    end
                endcase
            end
            zsvf_pkg::ST_FINISH: begin
                // Wait for room in the output register
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = zsvf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = zsvf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/zsvf_datapath.sv */
// ----------------------------------------------------------------------------
// zsvf_datapath
// Coefficient registers, integrator states, one split multiplier with a
// rounding accumulator, and the output register.
// ----------------------------------------------------------------------------
module zsvf_datapath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_valid,
    input  logic [zsvf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [zsvf_pkg::CFG_W-1:0]               cfg_data,
    input  logic signed [zsvf_pkg::SAMPLE_W-1:0]     s_sample_in,
    input  zsvf_pkg::cmd_t                           cmd,
    output zsvf_pkg::sts_t                           sts,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [zsvf_pkg::SAMPLE_W-1:0]     m_sample_out
);

    localparam int SAMPLE_W = zsvf_pkg::SAMPLE_W;
    localparam int STATE_W  = zsvf_pkg::STATE_W;
    localparam int NUM_W    = zsvf_pkg::NUM_W;
    localparam int LO_W     = zsvf_pkg::LO_W;
    localparam int HI_W     = zsvf_pkg::HI_W;
    localparam int COEF_W   = zsvf_pkg::COEF_W;
    localparam int MUL_A_W  = zsvf_pkg::MUL_A_W;
    localparam int MUL_B_W  = zsvf_pkg::MUL_B_W;
    localparam int PROD_W   = zsvf_pkg::PROD_W;
    localparam int ACC_W    = zsvf_pkg::ACC_W;
    localparam int RND_W    = zsvf_pkg::RND_W;

    // Configuration registers
    logic [zsvf_pkg::MODE_W-1:0] filter_mode_reg;
    logic [zsvf_pkg::G_W-1:0]    gain_g_reg;
    logic [zsvf_pkg::R_W-1:0]    damping_r_reg;
    logic [zsvf_pkg::INV_W-1:0]  inv_denom_reg;

    // Filter state and per-sample working registers
    logic signed [STATE_W-1:0]  integ_one_reg;
    logic signed [STATE_W-1:0]  integ_two_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [STATE_W-1:0]  hp_reg;
    logic signed [STATE_W-1:0]  bp_reg;
    logic signed [STATE_W-1:0]  lp_reg;
    logic signed [NUM_W-1:0]    gh_reg;
    logic signed [NUM_W-1:0]    gb_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                       out_valid_reg;

    logic [COEF_W-1:0]          damp_sum;
    logic [COEF_W-1:0]          coef;
    logic signed [NUM_W-1:0]    mul_a;
    logic signed [MUL_A_W-1:0]  lo_op;
    logic signed [MUL_A_W-1:0]  hi_op;
    logic signed [MUL_A_W-1:0]  mul_in;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    half;
    logic signed [ACC_W-1:0]    rnd_full;
    logic signed [RND_W-1:0]    rnd;
    logic signed [STATE_W-1:0]  sel;

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= zsvf_pkg::MODE_RESET;
            gain_g_reg      <= zsvf_pkg::G_RESET;
            damping_r_reg   <= zsvf_pkg::R_RESET;
            inv_denom_reg   <= zsvf_pkg::INV_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                zsvf_pkg::REG_FILTER_MODE: filter_mode_reg <= cfg_data[zsvf_pkg::MODE_W-1:0];
                zsvf_pkg::REG_GAIN_G:      gain_g_reg      <= cfg_data[zsvf_pkg::G_W-1:0];
                zsvf_pkg::REG_DAMPING_R:   damping_r_reg   <= cfg_data[zsvf_pkg::R_W-1:0];
                zsvf_pkg::REG_INV_DENOM:   inv_denom_reg   <= cfg_data[zsvf_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Form 2r+g in the gain format
    assign damp_sum = COEF_W'({damping_r_reg, {zsvf_pkg::R_SHIFT{1'b0}}})
                    + COEF_W'(gain_g_reg);

    // Pick operand, coefficient and rounding scale for the current product
    always_comb begin
        case (cmd.step)
            zsvf_pkg::STEP_DAMP: begin
                mul_a = {{(NUM_W-STATE_W){integ_one_reg[STATE_W-1]}}, integ_one_reg};
                coef  = damp_sum;
            end
            zsvf_pkg::STEP_INV: begin
                mul_a = num_reg;
                coef  = COEF_W'(inv_denom_reg);
            end
            zsvf_pkg::STEP_GH: begin
                mul_a = {{(NUM_W-STATE_W){hp_reg[STATE_W-1]}}, hp_reg};
                coef  = COEF_W'(gain_g_reg);
            end
            default: begin
                mul_a = {{(NUM_W-STATE_W){bp_reg[STATE_W-1]}}, bp_reg};
                coef  = COEF_W'(gain_g_reg);
            end
        endcase
        if (cmd.step == zsvf_pkg::STEP_INV) begin
            half     = zsvf_pkg::HALF_INV;
            rnd_full = acc_reg >>> zsvf_pkg::INV_FRAC;
        end else begin
            half     = zsvf_pkg::HALF_G;
            rnd_full = acc_reg >>> zsvf_pkg::G_FRAC;
        end
    end

    // Split the operand: unsigned low half, signed high half
    assign lo_op    = {1'b0, mul_a[LO_W-1:0]};
    assign hi_op    = {{(MUL_A_W-HI_W){mul_a[NUM_W-1]}}, mul_a[NUM_W-1:LO_W]};
    assign mul_in   = (cmd.phase == zsvf_pkg::MUL_HI) ? hi_op : lo_op;
    assign mul_b    = {1'b0, coef};
    assign prod     = mul_in * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign rnd      = rnd_full[RND_W-1:0];

    // Multiply low half, multiply high half, then accumulate with rounding
    always_ff @(posedge aclk) begin
        case (cmd.phase)
            zsvf_pkg::MUL_LO: begin
                prod_reg <= prod;
            end
            zsvf_pkg::MUL_HI: begin
                prod_reg <= prod;
                acc_reg  <= prod_ext + half;
            end
            zsvf_pkg::MUL_ACC: begin
                acc_reg <= acc_reg + (prod_ext <<< LO_W);
            end
            default: ;
        endcase
    end

    // Capture the sample and consume each rounded product
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= s_sample_in;
        end
        if (cmd.consume) begin
            case (cmd.step)
                zsvf_pkg::STEP_DAMP: begin
                    num_reg <= {{(NUM_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg}
                             - rnd[NUM_W-1:0]
                             - {{(NUM_W-STATE_W){integ_two_reg[STATE_W-1]}}, integ_two_reg};
                end
                zsvf_pkg::STEP_INV: begin
                    hp_reg <= zsvf_pkg::sat_state(rnd);
                end
                zsvf_pkg::STEP_GH: begin
                    gh_reg <= rnd[NUM_W-1:0];
                    bp_reg <= zsvf_pkg::sat_state(rnd
                        + {{(RND_W-STATE_W){integ_one_reg[STATE_W-1]}}, integ_one_reg});
                end
                default: begin
                    gb_reg <= rnd[NUM_W-1:0];
                    lp_reg <= zsvf_pkg::sat_state(rnd
                        + {{(RND_W-STATE_W){integ_two_reg[STATE_W-1]}}, integ_two_reg});
                end
            endcase
        end
    end

    // Select the response
    always_comb begin
        if ((filter_mode_reg & zsvf_pkg::MODE_HIGHPASS) != zsvf_pkg::MODE_LOWPASS) begin
            sel = hp_reg;
        end else if (filter_mode_reg == zsvf_pkg::MODE_BANDPASS) begin
            sel = bp_reg;
        end else begin
            sel = lp_reg;
        end
    end

    // Update integrators; first one after bandpass, second one at finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_one_reg <= '0;
            integ_two_reg <= '0;
        end else begin
            if (cmd.consume && cmd.step == zsvf_pkg::STEP_GB) begin
                integ_one_reg <= zsvf_pkg::sat_state(
                    {{(RND_W-NUM_W){gh_reg[NUM_W-1]}}, gh_reg}
                    + {{(RND_W-STATE_W){bp_reg[STATE_W-1]}}, bp_reg});
            end
            if (cmd.finish) begin
                integ_two_reg <= zsvf_pkg::sat_state(
                    {{(RND_W-NUM_W){gb_reg[NUM_W-1]}}, gb_reg}
                    + {{(RND_W-STATE_W){lp_reg[STATE_W-1]}}, lp_reg});
            end
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= zsvf_pkg::sat_sample(sel);
        end
    end

    assign sts.out_free = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_reg;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives zdf_state_variable_filter with a short scripted sequence and then
// random phases of coefficients and samples. A bit-exact fixed-point copy of
// the filter predicts each output beat the script does not give, and each beat is compared in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SAMPLE_W  = zsvf_pkg::SAMPLE_W;
    localparam int STATE_W   = zsvf_pkg::STATE_W;
    localparam int MODE_W    = zsvf_pkg::MODE_W;
    localparam int G_W       = zsvf_pkg::G_W;
    localparam int R_W       = zsvf_pkg::R_W;
    localparam int INV_W     = zsvf_pkg::INV_W;
    localparam int G_FRAC    = zsvf_pkg::G_FRAC;
    localparam int INV_FRAC  = zsvf_pkg::INV_FRAC;
    localparam int R_SHIFT   = zsvf_pkg::R_SHIFT;
    localparam int CFG_W     = zsvf_pkg::CFG_W;
    localparam int CFG_IDX_W = zsvf_pkg::CFG_IDX_W;

    typedef logic signed [79:0] wide_t;

    // One line of the scripted sequence: a register write or a sample
    typedef struct {
        bit                         is_write;
        zsvf_pkg::cfg_reg_t         reg_sel;
        logic [CFG_W-1:0]           wdata;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] want;
    } script_row_t;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam logic [INV_W-1:0]  INV_UNITY   = 25'd16777216;
    localparam int                SETTLE      = 24;
    localparam int                HOLD_CYCLES = 300;
    localparam int                WATCHDOG    = 4000;
    localparam int                PHASES      = 10;
    localparam int                PHASE_BEATS = 63;
    localparam int                SQUEEZE_PH  = 3;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;

    // Shadow of the coefficient registers and the two integrators
    logic [MODE_W-1:0]          cur_mode;
    logic [G_W-1:0]             cur_gain;
    logic [R_W-1:0]             cur_damp;
    logic [INV_W-1:0]           cur_inv;
    logic signed [STATE_W-1:0]  bp_integ;
    logic signed [STATE_W-1:0]  lp_integ;

    logic signed [SAMPLE_W-1:0] predicted_samples[$];
    int                         mismatches;
    int                         quiet_cycles;
    bit                         tx_no_gap;
    bit                         rx_no_stall;
    bit                         hold_request;

    zdf_state_variable_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Round v*coef/2^shift half upward
    function automatic wide_t round_mul(wide_t v, wide_t coef, int shift);
        return (v * coef + (wide_t'(1) <<< (shift - 1))) >>> shift;
    endfunction

    // Clamp to a signed range of w bits
    function automatic wide_t clip(wide_t v, int w);
        wide_t top;
        top = (wide_t'(1) <<< (w - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // Advance the integrators by one sample and return the selected response
    function automatic logic signed [SAMPLE_W-1:0] filter_step(
        input logic signed [SAMPLE_W-1:0] x
    );
        wide_t s1, s2, g, damp_sum, num, hp, bp, lp, gh, gb, pick;
        s1 = bp_integ;
        s2 = lp_integ;
        g = wide_t'(cur_gain);
        damp_sum = (wide_t'(cur_damp) <<< R_SHIFT) + g;
        num = wide_t'(x) - round_mul(s1, damp_sum, G_FRAC) - s2;
        hp = clip(round_mul(num, wide_t'(cur_inv), INV_FRAC), STATE_W);
        gh = round_mul(hp, g, G_FRAC);
        bp = clip(gh + s1, STATE_W);
        gb = round_mul(bp, g, G_FRAC);
        lp = clip(gb + s2, STATE_W);
        bp_integ = STATE_W'(clip(gh + bp, STATE_W));
        lp_integ = STATE_W'(clip(gb + lp, STATE_W));
        if (cur_mode[1]) begin
            pick = hp;
        end else if (cur_mode == zsvf_pkg::MODE_BANDPASS) begin
            pick = bp;
        end else begin
            pick = lp;
        end
        pick = clip(pick, SAMPLE_W);
        return pick[SAMPLE_W-1:0];
    endfunction

    function automatic script_row_t write_row(zsvf_pkg::cfg_reg_t idx,
                                              logic [CFG_W-1:0] val);
        script_row_t r;
        r.is_write = 1'b1;
        r.reg_sel  = idx;
        r.wdata    = val;
        r.smp      = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic script_row_t sample_row(
        logic signed [SAMPLE_W-1:0] x, bit typed, logic signed [SAMPLE_W-1:0] want
    );
        script_row_t r;
        r.is_write = 1'b0;
        r.reg_sel  = zsvf_pkg::REG_FILTER_MODE;
        r.wdata    = '0;
        r.smp      = x;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    // Write one register; the caller drops cfg_valid after the last write
    task automatic write_reg(zsvf_pkg::cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            zsvf_pkg::REG_FILTER_MODE: cur_mode = val[MODE_W-1:0];
            zsvf_pkg::REG_GAIN_G:      cur_gain = val[G_W-1:0];
            zsvf_pkg::REG_DAMPING_R:   cur_damp = val[R_W-1:0];
            zsvf_pkg::REG_INV_DENOM:   cur_inv  = val[INV_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Offer one sample after a random gap and record its prediction on the beat
    task automatic send_sample(
        logic signed [SAMPLE_W-1:0] x, bit typed, logic signed [SAMPLE_W-1:0] want
    );
        int gap;
        logic signed [SAMPLE_W-1:0] guess;
        gap = tx_no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (!(s_valid && s_ready));
        guess = filter_step(x);
        predicted_samples.push_back(typed ? want : guess);
        @(negedge aclk);
    endtask

    // Drain every pending output and let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (predicted_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Stimulus: scripted rows, then random phases
    initial begin
        script_row_t script[$];
        bit          prev_write;
        logic [MODE_W-1:0] mode_v;
        logic [G_W-1:0]    g_v;
        logic [R_W-1:0]    r_v;
        logic [INV_W-1:0]  inv_v;
        logic signed [SAMPLE_W-1:0] x;
        real gr, rr;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_sample_in  = '0;
        tx_no_gap    = 1'b0;
        rx_no_stall  = 1'b0;
        hold_request = 1'b0;
        mismatches   = 0;
        cur_mode     = zsvf_pkg::MODE_RESET;
        cur_gain     = zsvf_pkg::G_RESET;
        cur_damp     = zsvf_pkg::R_RESET;
        cur_inv      = zsvf_pkg::INV_RESET;
        bp_integ     = '0;
        lp_integ     = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With zero gain and unity reciprocal the integrators stay at zero,
        // so highpass passes the sample and the other taps read zero
        script = '{
            sample_row('0, 1'b1, '0),
            write_row(zsvf_pkg::REG_FILTER_MODE, CFG_W'(zsvf_pkg::MODE_HIGHPASS)),
            write_row(zsvf_pkg::REG_GAIN_G, '0),
            write_row(zsvf_pkg::REG_INV_DENOM, INV_UNITY),
            sample_row(SMP_MAX, 1'b1, SMP_MAX),
            sample_row(SMP_MIN, 1'b1, SMP_MIN),
            sample_row('0, 1'b1, '0),
            write_row(zsvf_pkg::REG_FILTER_MODE, CFG_W'(MODE_SPARE)),
            sample_row(24'sd4660, 1'b1, 24'sd4660),
            sample_row(-24'sd1, 1'b1, -24'sd1),
            write_row(zsvf_pkg::REG_INV_DENOM, '0),
            sample_row(SMP_MAX, 1'b1, '0),
            write_row(zsvf_pkg::REG_FILTER_MODE, CFG_W'(zsvf_pkg::MODE_BANDPASS)),
            sample_row(SMP_MIN, 1'b1, '0),
            write_row(zsvf_pkg::REG_FILTER_MODE, CFG_W'(zsvf_pkg::MODE_LOWPASS)),
            sample_row(SMP_MAX, 1'b1, '0),
            write_row(zsvf_pkg::REG_GAIN_G, CFG_W'(zsvf_pkg::G_RESET)),
            write_row(zsvf_pkg::REG_INV_DENOM, CFG_W'(zsvf_pkg::INV_RESET)),
            sample_row(SMP_MAX, 1'b0, '0),
            sample_row(SMP_MAX, 1'b0, '0),
            sample_row(SMP_MIN, 1'b0, '0),
            write_row(zsvf_pkg::REG_FILTER_MODE, CFG_W'(zsvf_pkg::MODE_BANDPASS)),
            sample_row(24'sd1000, 1'b0, '0),
            write_row(zsvf_pkg::REG_FILTER_MODE, CFG_W'(zsvf_pkg::MODE_HIGHPASS)),
            write_row(zsvf_pkg::REG_GAIN_G, CFG_W'({G_W{1'b1}})),
            write_row(zsvf_pkg::REG_DAMPING_R, CFG_W'({R_W{1'b1}})),
            write_row(zsvf_pkg::REG_INV_DENOM, CFG_W'({INV_W{1'b1}})),
            sample_row(SMP_MAX, 1'b0, '0),
            sample_row(SMP_MIN, 1'b0, '0),
            sample_row(24'sd5, 1'b0, '0),
            write_row(zsvf_pkg::REG_DAMPING_R, '0),
            write_row(zsvf_pkg::REG_GAIN_G, CFG_W'(24'd1)),
            sample_row(SMP_MIN, 1'b0, '0),
            sample_row(SMP_MAX, 1'b0, '0)
        };

        // Walk the script; writes only go out once the filter is idle
        prev_write = 1'b1;
        foreach (script[i]) begin
            if (script[i].is_write) begin
                if (!prev_write) wait_idle();
                write_reg(script[i].reg_sel, script[i].wdata);
            end else begin
                if (prev_write) cfg_valid <= 1'b0;
                send_sample(script[i].smp, script[i].typed, script[i].want);
            end
            prev_write = script[i].is_write;
        end
        wait_idle();

        // Random phases: extremes first, then a mix of sane and wild settings
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                mode_v = MODE_SPARE;
                g_v    = {G_W{1'b1}};
                r_v    = {R_W{1'b1}};
                inv_v  = {INV_W{1'b1}};
            end else if (ph == 1) begin
                mode_v = zsvf_pkg::MODE_LOWPASS;
                g_v    = '0;
                r_v    = '0;
                inv_v  = INV_UNITY;
            end else if ($urandom_range(0, 2) == 0) begin
                mode_v = MODE_W'($urandom_range(0, 3));
                g_v    = G_W'($urandom_range(0, 24'hFFFFFF));
                r_v    = R_W'($urandom_range(0, 17'h1FFFF));
                inv_v  = INV_W'($urandom_range(0, 25'h1FFFFFF));
            end else begin
                mode_v = MODE_W'($urandom_range(0, 3));
                g_v    = G_W'($urandom_range(2000, 3000000));
                r_v    = R_W'($urandom_range(328, 65536));
                gr     = g_v / 1048576.0;
                rr     = r_v / 65536.0;
                inv_v  = INV_W'($rtoi(16777216.0 / (1.0 + 2.0 * rr * gr + gr * gr) + 0.5));
            end
            tx_no_gap   = (ph % 4 == 2) || (ph == SQUEEZE_PH);
            rx_no_stall = (ph % 4 == 2);
            if (ph == SQUEEZE_PH) hold_request = 1'b1;

            write_reg(zsvf_pkg::REG_FILTER_MODE, CFG_W'(mode_v));
            write_reg(zsvf_pkg::REG_GAIN_G, CFG_W'(g_v));
            write_reg(zsvf_pkg::REG_DAMPING_R, CFG_W'(r_v));
            write_reg(zsvf_pkg::REG_INV_DENOM, CFG_W'(inv_v));
            cfg_valid <= 1'b0;

            for (int n = 0; n < PHASE_BEATS; n++) begin
                case ($urandom_range(0, 9))
                    0:       x = SMP_MAX;
                    1:       x = SMP_MIN;
                    2, 3:    x = SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
                    default: x = SAMPLE_W'($urandom());
                endcase
                send_sample(x, 1'b0, '0);
            end
            wait_idle();
        end

        mismatches += predicted_samples.size();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Output side: stall at random, with one long hold when asked
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 10);
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // Compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_samples.size() == 0) begin
                if (mismatches < 10)
                    $display("output beat with nothing pending: sample_out=%0d", m_sample_out);
                mismatches++;
            end else begin
                want = predicted_samples.pop_front();
                if (m_sample_out !== want) begin
                    if (mismatches < 10)
                        $display("sample_out mismatch: expected %0d, got %0d",
                                 want, m_sample_out);
                    mismatches++;
                end
            end
        end
    end

    // Abort when no channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* zdf_state_variable_filter.f */
+incdir+rtl/core
rtl/core/zsvf_pkg.sv
rtl/core/zsvf_ctrl.sv
rtl/core/zsvf_datapath.sv
rtl/core/zdf_state_variable_filter.sv
bench/testbench.sv
